@@ rtl/rgba_ob_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and divide-by-255 helpers for the RGBA overlay blender.
// No dependencies.
package rgba_ob_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int POS_W      = 12;
    localparam int SPAN_W     = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_Y = 3'd3;

    localparam logic [7:0] ALPHA_FULL = 8'd255;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [7:0] t_chan;

    typedef struct packed {
        logic  in_win;
        logic  opaque;
        t_chan back_red;
        t_chan back_green;
        t_chan back_blue;
        t_chan back_alpha;
        t_chan over_red;
        t_chan over_green;
        t_chan over_blue;
        t_chan over_alpha;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry data;
    } t_xfer;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic  valid;
        t_chan red;
        t_chan green;
        t_chan blue;
        t_chan alpha;
        logic  in_window;
    } t_result;

    // lower bound of x/255, never more than one below the true quotient
    function automatic logic [16:0] div255_est(input logic [23:0] x);
        logic [41:0] s;
        s = {18'd0, x} + {10'd0, x, 8'd0} + {2'd0, x, 16'd0};
        return s[40:24];
    endfunction

    function automatic logic [16:0] div255_fix(input logic [23:0] x, input logic [16:0] est);
        logic [24:0] prod;
        logic [24:0] rem;
        prod = {est, 8'd0} - {8'd0, est};
        rem  = {1'b0, x} - prod;
        return est + 17'(rem >= 25'd255);
    endfunction

endpackage

@@ rtl/rgba_ob_front.sv @@
`timescale 1ns / 1ps
// Front end: window registers, item acceptance and inside/opaque classification.
// Depends on rgba_ob_pkg.
module rgba_ob_front
    import rgba_ob_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start,
    input  logic [POS_W-1:0]      i_pixel_row,
    input  logic [POS_W-1:0]      i_pixel_col,
    input  t_chan                 i_back_red,
    input  t_chan                 i_back_green,
    input  t_chan                 i_back_blue,
    input  t_chan                 i_back_alpha,
    input  t_chan                 i_over_red,
    input  t_chan                 i_over_green,
    input  t_chan                 i_over_blue,
    input  t_chan                 i_over_alpha,
    input  t_q_status             i_q_status,
    output logic                  o_busy,
    output t_xfer                 o_push
);

    localparam int LIM_W = $clog2(MAX_DIM + 1);
    localparam int EXT_W = ((LIM_W > SPAN_W) ? LIM_W : SPAN_W) + 1;
    localparam logic [EXT_W-1:0] LIM = EXT_W'(MAX_DIM);

    logic [POS_W-1:0]  r_left, r_top;
    logic [SPAN_W-1:0] r_span_x, r_span_y;
    logic              r_valid, n_valid;
    t_entry            r_entry;

    logic              ready, accept, push;
    logic [EXT_W-1:0]  span_x, span_y, edge_x, edge_y;
    logic              hit;

    assign ready  = !r_valid || !i_q_status.full;
    assign accept = i_start && ready && i_rst_n;
    assign push   = r_valid && !i_q_status.full;
    assign o_busy = !ready || !i_rst_n;

    always_comb begin
        span_x = (EXT_W'(r_span_x) > LIM) ? LIM : EXT_W'(r_span_x);
        span_y = (EXT_W'(r_span_y) > LIM) ? LIM : EXT_W'(r_span_y);
        edge_x = EXT_W'(r_left) + span_x;
        edge_y = EXT_W'(r_top) + span_y;
        hit    = (i_pixel_row >= r_top) && (EXT_W'(i_pixel_row) < edge_y)
              && (i_pixel_col >= r_left) && (EXT_W'(i_pixel_col) < edge_x);
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_span_x <= '0;
            r_span_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEFT:   r_left   <= i_cfg_data[POS_W-1:0];
                CFG_TOP:    r_top    <= i_cfg_data[POS_W-1:0];
                CFG_SPAN_X: r_span_x <= i_cfg_data[SPAN_W-1:0];
                CFG_SPAN_Y: r_span_y <= i_cfg_data[SPAN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry.in_win     <= hit;
            r_entry.opaque     <= (i_over_alpha == ALPHA_FULL);
            r_entry.back_red   <= i_back_red;
            r_entry.back_green <= i_back_green;
            r_entry.back_blue  <= i_back_blue;
            r_entry.back_alpha <= i_back_alpha;
            r_entry.over_red   <= i_over_red;
            r_entry.over_green <= i_over_green;
            r_entry.over_blue  <= i_over_blue;
            r_entry.over_alpha <= i_over_alpha;
        end
    end

    assign o_push.valid = push;
    assign o_push.data  = r_entry;

endmodule

@@ rtl/rgba_ob_queue.sv @@
`timescale 1ns / 1ps
// Short transaction queue between front end and blend pipeline.
// Depends on rgba_ob_pkg.
module rgba_ob_queue
    import rgba_ob_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_xfer     i_push,
    output t_q_status o_status,
    output t_xfer     o_pop
);

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_push, do_pop;

    assign do_pop  = (r_count != '0);
    assign do_push = i_push.valid && (r_count != Q_CNT_W'(Q_DEPTH));

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_pop.valid    = do_pop;
    assign o_pop.data     = r_mem[r_rd_ptr];

endmodule

@@ rtl/rgba_ob_back.sv @@
`timescale 1ns / 1ps
// Blend pipeline: six stages of multiply, divide by 255 and final select.
// Depends on rgba_ob_pkg.
module rgba_ob_back
    import rgba_ob_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_xfer   i_item,
    output t_result o_result
);

    logic [5:0] r_vld;
    t_entry     r1_e, r2_e, r3_e, r4_e, r5_e;

    // stage 1
    logic [15:0] r1_t, r1_oc_r, r1_oc_g, r1_oc_b;
    // stage 2
    logic [15:0] r2_t, r2_oc_r, r2_oc_g, r2_oc_b;
    logic [23:0] r2_u_r, r2_u_g, r2_u_b;
    // stage 3
    logic [15:0] r3_t, r3_oc_r, r3_oc_g, r3_oc_b;
    logic [23:0] r3_u_r, r3_u_g, r3_u_b;
    logic [16:0] r3_e_t, r3_e_r, r3_e_g, r3_e_b;
    // stage 4
    logic [16:0] r4_v_r, r4_v_g, r4_v_b;
    t_chan       r4_alpha;
    // stage 5
    logic [16:0] r5_v_r, r5_v_g, r5_v_b;
    logic [16:0] r5_e_r, r5_e_g, r5_e_b;
    t_chan       r5_alpha;
    // stage 6
    t_chan       r6_red, r6_green, r6_blue, r6_alpha;
    logic        r6_win;

    t_chan       comp;
    logic [16:0] bp_t, bp_r, bp_g, bp_b;
    logic [16:0] q_r, q_g, q_b;

    assign comp = ALPHA_FULL - i_item.data.over_alpha;
    assign bp_t = div255_fix({8'd0, r3_t}, r3_e_t);
    assign bp_r = div255_fix(r3_u_r, r3_e_r);
    assign bp_g = div255_fix(r3_u_g, r3_e_g);
    assign bp_b = div255_fix(r3_u_b, r3_e_b);
    assign q_r  = div255_fix({7'd0, r5_v_r}, r5_e_r);
    assign q_g  = div255_fix({7'd0, r5_v_g}, r5_e_g);
    assign q_b  = div255_fix({7'd0, r5_v_b}, r5_e_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_item.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_e    <= i_item.data;
        r1_t    <= i_item.data.back_alpha * comp;
        r1_oc_r <= i_item.data.over_alpha * i_item.data.over_red;
        r1_oc_g <= i_item.data.over_alpha * i_item.data.over_green;
        r1_oc_b <= i_item.data.over_alpha * i_item.data.over_blue;

        r2_e    <= r1_e;
        r2_t    <= r1_t;
        r2_oc_r <= r1_oc_r;
        r2_oc_g <= r1_oc_g;
        r2_oc_b <= r1_oc_b;
        r2_u_r  <= r1_t * r1_e.back_red;
        r2_u_g  <= r1_t * r1_e.back_green;
        r2_u_b  <= r1_t * r1_e.back_blue;

        r3_e    <= r2_e;
        r3_t    <= r2_t;
        r3_oc_r <= r2_oc_r;
        r3_oc_g <= r2_oc_g;
        r3_oc_b <= r2_oc_b;
        r3_u_r  <= r2_u_r;
        r3_u_g  <= r2_u_g;
        r3_u_b  <= r2_u_b;
        r3_e_t  <= div255_est({8'd0, r2_t});
        r3_e_r  <= div255_est(r2_u_r);
        r3_e_g  <= div255_est(r2_u_g);
        r3_e_b  <= div255_est(r2_u_b);

        r4_e     <= r3_e;
        r4_v_r   <= {1'b0, r3_oc_r} + bp_r;
        r4_v_g   <= {1'b0, r3_oc_g} + bp_g;
        r4_v_b   <= {1'b0, r3_oc_b} + bp_b;
        r4_alpha <= r3_e.over_alpha + bp_t[7:0];

        r5_e     <= r4_e;
        r5_v_r   <= r4_v_r;
        r5_v_g   <= r4_v_g;
        r5_v_b   <= r4_v_b;
        r5_e_r   <= div255_est({7'd0, r4_v_r});
        r5_e_g   <= div255_est({7'd0, r4_v_g});
        r5_e_b   <= div255_est({7'd0, r4_v_b});
        r5_alpha <= r4_alpha;

        r6_win <= r5_e.in_win;
        if (!r5_e.in_win) begin
            r6_red   <= r5_e.back_red;
            r6_green <= r5_e.back_green;
            r6_blue  <= r5_e.back_blue;
            r6_alpha <= r5_e.back_alpha;
        end else if (r5_e.opaque) begin
            r6_red   <= r5_e.over_red;
            r6_green <= r5_e.over_green;
            r6_blue  <= r5_e.over_blue;
            r6_alpha <= r5_e.over_alpha;
        end else begin
            r6_red   <= q_r[7:0];
            r6_green <= q_g[7:0];
            r6_blue  <= q_b[7:0];
            r6_alpha <= r5_alpha;
        end
    end

    assign o_result = '{valid: r_vld[5], red: r6_red, green: r6_green, blue: r6_blue,
                        alpha: r6_alpha, in_window: r6_win};

endmodule

@@ rtl/rgba_overlay_alpha_blend.sv @@
`timescale 1ns / 1ps
// Top level of the RGBA overlay blender: front end, queue and blend pipeline.
// Throughput: one pixel per cycle.
// The rate is set by the six-stage blend pipeline, which takes a new transaction every cycle.
// Reset is synchronous active low: clears window registers to 0 and drops all work in flight.
// Depends on rgba_ob_pkg, rgba_ob_front, rgba_ob_queue, rgba_ob_back.
module rgba_overlay_alpha_blend
    import rgba_ob_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [POS_W-1:0]      i_pixel_row,
    input  logic [POS_W-1:0]      i_pixel_col,
    input  logic [7:0]            i_back_red,
    input  logic [7:0]            i_back_green,
    input  logic [7:0]            i_back_blue,
    input  logic [7:0]            i_back_alpha,
    input  logic [7:0]            i_over_red,
    input  logic [7:0]            i_over_green,
    input  logic [7:0]            i_over_blue,
    input  logic [7:0]            i_over_alpha,
    output logic                  o_valid,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic [7:0]            o_out_alpha,
    output logic                  o_in_window
);

    t_xfer     push, pop;
    t_q_status q_status;
    t_result   result;

    rgba_ob_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_start      (i_start),
        .i_pixel_row  (i_pixel_row),
        .i_pixel_col  (i_pixel_col),
        .i_back_red   (i_back_red),
        .i_back_green (i_back_green),
        .i_back_blue  (i_back_blue),
        .i_back_alpha (i_back_alpha),
        .i_over_red   (i_over_red),
        .i_over_green (i_over_green),
        .i_over_blue  (i_over_blue),
        .i_over_alpha (i_over_alpha),
        .i_q_status   (q_status),
        .o_busy       (o_busy),
        .o_push       (push)
    );

    rgba_ob_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_status (q_status),
        .o_pop    (pop)
    );

    rgba_ob_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (pop),
        .o_result (result)
    );

    assign o_valid     = result.valid;
    assign o_out_red   = result.red;
    assign o_out_green = result.green;
    assign o_out_blue  = result.blue;
    assign o_out_alpha = result.alpha;
    assign o_in_window = result.in_window;

    logic accept;
    assign accept = i_start && !o_busy;

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##7 o_valid)
        else $error("accepted transaction produced no result after 8 cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 8))
        else $error("result strobe without a matching transaction");

    a_queue_never_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_status.full)
        else $error("queue filled although the blend pipeline never stalls");

endmodule
